// ===== rtl/tpp_pkg.sv =====
// Shared types and constants of the transfer packet parser.
`timescale 1ns / 1ps

package tpp_pkg;

  localparam int unsigned MAX_PACKET    = 1024;
  localparam int unsigned NAME_CAPACITY = 256;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd997;

  // control bytes
  localparam logic [7:0] CTL_DATA  = 8'h01;
  localparam logic [7:0] CTL_START = 8'h02;
  localparam logic [7:0] CTL_END   = 8'h03;

  // TLV tags
  localparam logic [7:0] TAG_SIZE = 8'h00;
  localparam logic [7:0] TAG_NAME = 8'h01;

  // result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdict codes
  localparam logic [2:0] VERDICT_START_OK  = 3'd0;
  localparam logic [2:0] VERDICT_DATA_OK   = 3'd1;
  localparam logic [2:0] VERDICT_END_MATCH = 3'd2;
  localparam logic [2:0] VERDICT_END_MISS  = 3'd3;
  localparam logic [2:0] VERDICT_IGNORED   = 3'd4;

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_WAIT = 2'b01,
    PH_RECV = 2'b10
  } phase_t;

  typedef enum logic [2:0] {
    STEP_TYPE  = 3'b001,
    STEP_LEN   = 3'b010,
    STEP_VALUE = 3'b100
  } field_step_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [2:0]  verdict;
    logic [63:0] file_size;
    logic [63:0] received_total;
    logic        out_last;
  } result_t;

  // up to two results per byte, pushed in order: first, then second
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

endpackage

// ===== rtl/tpp_ifs.sv =====
// Valid/ready channel interfaces for packet bytes and parser results.
`timescale 1ns / 1ps

interface tpp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface tpp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [2:0]  verdict;
  logic [63:0] file_size;
  logic [63:0] received_total;
  logic        out_last;

  modport source (output valid, output out_kind, output out_byte, output verdict,
                  output file_size, output received_total, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input verdict,
                  input file_size, input received_total, input out_last,
                  output ready);
endinterface

// ===== rtl/tpp_parse_core.sv =====
// Input register, parser state and per-byte step logic.
`timescale 1ns / 1ps

module tpp_parse_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  tpp_item_if.sink      pkt,
  input  logic          room,
  output tpp_pkg::push_t push
);
  import tpp_pkg::*;

  // input register
  logic       item_v;
  logic [7:0] item_byte;
  logic       item_eop;

  // parser state
  logic [15:0]  max_payload;
  phase_t       phase;
  logic [15:0]  byte_index;
  logic [7:0]   packet_control;
  field_step_t  field_step;
  logic [7:0]   field_type;
  logic [7:0]   field_remaining;
  logic [7:0]   name_count;
  logic         packet_bad;
  logic         size_found;
  logic [63:0]  size_acc;
  logic [15:0]  payload_length;
  logic [63:0]  expected_size;
  logic [63:0]  written_total;

  phase_t       phase_next;
  logic [15:0]  byte_index_next;
  logic [7:0]   packet_control_next;
  field_step_t  field_step_next;
  logic [7:0]   field_type_next;
  logic [7:0]   field_remaining_next;
  logic [7:0]   name_count_next;
  logic         packet_bad_next;
  logic         size_found_next;
  logic [63:0]  size_acc_next;
  logic [15:0]  payload_length_next;
  logic [63:0]  expected_size_next;
  logic [63:0]  written_total_next;

  logic         process;
  logic         emit;
  logic [1:0]   emit_kind;
  logic [2:0]   verdict;
  logic [7:0]   rem_dec;
  logic [16:0]  need_cnt;
  result_t      emit_res;
  result_t      verdict_res;

  assign process   = item_v && room;
  assign pkt.ready = !item_v || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (pkt.valid && pkt.ready) begin
      item_v <= 1'b1;
    end else if (process) begin
      item_v <= 1'b0;
    end
    if (pkt.valid && pkt.ready) begin
      item_byte <= pkt.rx_byte;
      item_eop  <= pkt.end_of_packet;
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_index_next      = (byte_index == 16'hFFFF) ? byte_index : byte_index + 16'd1;
    packet_control_next  = packet_control;
    field_step_next      = field_step;
    field_type_next      = field_type;
    field_remaining_next = field_remaining;
    name_count_next      = name_count;
    packet_bad_next      = packet_bad || (byte_index >= 16'(MAX_PACKET));
    size_found_next      = size_found;
    size_acc_next        = size_acc;
    payload_length_next  = payload_length;
    expected_size_next   = expected_size;
    written_total_next   = written_total;
    emit                 = 1'b0;
    emit_kind            = KIND_NAME;
    verdict              = VERDICT_IGNORED;
    rem_dec              = field_remaining - 8'd1;
    need_cnt             = 17'd0;

    unique case (phase)
      PH_WAIT: begin
        if (byte_index == 16'd0) begin
          packet_control_next = item_byte;
          field_step_next     = STEP_TYPE;
          if (item_byte != CTL_START) packet_bad_next = 1'b1;
        end else if (!packet_bad_next) begin
          unique case (field_step)
            STEP_TYPE: begin
              field_type_next = item_byte;
              field_step_next = STEP_LEN;
            end
            STEP_LEN: begin
              field_remaining_next = item_byte;
              if (field_type == TAG_SIZE) begin
                size_acc_next   = 64'd0;
                size_found_next = 1'b1;
              end else if (field_type == TAG_NAME) begin
                name_count_next = 8'd0;
              end
              field_step_next = (item_byte != 8'd0) ? STEP_VALUE : STEP_TYPE;
            end
            STEP_VALUE: begin
              if (field_type == TAG_SIZE) begin
                size_acc_next = {size_acc[55:0], item_byte};
              end else if (field_type == TAG_NAME &&
                           name_count < 8'(NAME_CAPACITY - 1)) begin
                emit            = 1'b1;
                emit_kind       = KIND_NAME;
                name_count_next = name_count + 8'd1;
              end
              field_remaining_next = rem_dec;
              if (rem_dec == 8'd0) field_step_next = STEP_TYPE;
            end
            default: field_step_next = STEP_TYPE;
          endcase
        end
      end
      PH_RECV: begin
        if (byte_index == 16'd0) begin
          packet_control_next = item_byte;
        end else if (packet_control == CTL_DATA) begin
          if (byte_index == 16'd1) begin
            payload_length_next = {item_byte, 8'd0};
          end else if (byte_index == 16'd2) begin
            payload_length_next = {payload_length[15:8], item_byte};
            if ({payload_length[15:8], item_byte} > max_payload) packet_bad_next = 1'b1;
          end else if (!packet_bad_next && (byte_index - 16'd3) < payload_length) begin
            emit      = 1'b1;
            emit_kind = KIND_PAYLOAD;
          end
        end
      end
      default: phase_next = PH_WAIT;
    endcase

    // packet end: verdict, then a clean slate for the next packet
    if (item_eop) begin
      need_cnt = {1'b0, payload_length_next} + 17'd3;
      unique case (phase)
        PH_WAIT: begin
          if (field_step_next == STEP_VALUE) packet_bad_next = 1'b1;
          if (!packet_bad_next && size_found_next) begin
            expected_size_next = size_acc_next;
            written_total_next = 64'd0;
            phase_next         = PH_RECV;
            verdict            = VERDICT_START_OK;
          end
        end
        PH_RECV: begin
          if (packet_control_next == CTL_DATA) begin
            if (!packet_bad_next && byte_index_next >= 16'd3 &&
                {1'b0, byte_index_next} >= need_cnt) begin
              written_total_next = written_total + {48'd0, payload_length_next};
              verdict            = VERDICT_DATA_OK;
            end
          end else if (packet_control_next == CTL_END && !packet_bad_next) begin
            verdict    = (written_total == expected_size) ? VERDICT_END_MATCH
                                                          : VERDICT_END_MISS;
            phase_next = PH_WAIT;
          end
        end
        default: phase_next = PH_WAIT;
      endcase
      byte_index_next      = 16'd0;
      packet_control_next  = 8'd0;
      field_step_next      = STEP_TYPE;
      field_type_next      = 8'd0;
      field_remaining_next = 8'd0;
      name_count_next      = 8'd0;
      packet_bad_next      = 1'b0;
      size_found_next      = 1'b0;
      size_acc_next        = 64'd0;
      payload_length_next  = 16'd0;
    end

    emit_res.out_kind       = emit_kind;
    emit_res.out_byte       = item_byte;
    emit_res.verdict        = VERDICT_START_OK;
    emit_res.file_size      = expected_size;
    emit_res.received_total = written_total;
    emit_res.out_last       = !item_eop;

    verdict_res.out_kind       = KIND_VERDICT;
    verdict_res.out_byte       = 8'd0;
    verdict_res.verdict        = verdict;
    verdict_res.file_size      = expected_size_next;
    verdict_res.received_total = written_total_next;
    verdict_res.out_last       = 1'b1;

    push.first_valid  = process && (emit || item_eop);
    push.second_valid = process && emit && item_eop;
    push.first        = emit ? emit_res : verdict_res;
    push.second       = verdict_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload     <= MAX_PAYLOAD_RESET;
      phase           <= PH_WAIT;
      byte_index      <= 16'd0;
      packet_control  <= 8'd0;
      field_step      <= STEP_TYPE;
      field_type      <= 8'd0;
      field_remaining <= 8'd0;
      name_count      <= 8'd0;
      packet_bad      <= 1'b0;
      size_found      <= 1'b0;
      size_acc        <= 64'd0;
      payload_length  <= 16'd0;
      expected_size   <= 64'd0;
      written_total   <= 64'd0;
    end else begin
      if (cfg_we) max_payload <= cfg_wdata;
      if (process) begin
        phase           <= phase_next;
        byte_index      <= byte_index_next;
        packet_control  <= packet_control_next;
        field_step      <= field_step_next;
        field_type      <= field_type_next;
        field_remaining <= field_remaining_next;
        name_count      <= name_count_next;
        packet_bad      <= packet_bad_next;
        size_found      <= size_found_next;
        size_acc        <= size_acc_next;
        payload_length  <= payload_length_next;
        expected_size   <= expected_size_next;
        written_total   <= written_total_next;
      end
    end
  end

endmodule

// ===== rtl/tpp_result_fifo.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module tpp_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  tpp_pkg::push_t push,
  output logic           room,
  tpp_result_if.source   res
);
  import tpp_pkg::*;

  result_t                q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   head;
  logic [RES_PTR_W-1:0]   tail;
  logic [RES_CNT_W-1:0]   count;
  logic [RES_PTR_W-1:0]   tail_plus;
  logic [1:0]             push_n;
  logic                   pop;

  assign tail_plus = tail + RES_PTR_W'(1);
  assign push_n    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
  assign pop       = res.valid && res.ready;
  // room for a full two-result push
  assign room      = count <= RES_CNT_W'(RES_DEPTH - 2);

  assign res.valid          = count != '0;
  assign res.out_kind       = q[head].out_kind;
  assign res.out_byte       = q[head].out_byte;
  assign res.verdict        = q[head].verdict;
  assign res.file_size      = q[head].file_size;
  assign res.received_total = q[head].received_total;
  assign res.out_last       = q[head].out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + RES_PTR_W'(1);
      tail  <= tail + RES_PTR_W'(push_n);
      count <= count + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
    if (push.first_valid)  q[tail]      <= push.first;
    if (push.second_valid) q[tail_plus] <= push.second;
  end

endmodule

// ===== rtl/transfer_packet_parser_top.sv =====
// Top level of the transfer packet parser.
`timescale 1ns / 1ps

//  channel   | dir | payload                                        | transfer when
//  ----------+-----+------------------------------------------------+----------------------
//  pkt       | in  | rx_byte, end_of_packet                         | pkt.valid & pkt.ready
//  res       | out | out_kind, out_byte, verdict, file_size,        | res.valid & res.ready
//            |     | received_total, out_last                       |
//  cfg_we/.. | in  | cfg_wdata -> max_payload                       | cfg_we
//
//  One byte per cycle while the queue has room: a byte waits in the input register,
//  its step logic runs while it waits there and its results land in a 4-entry queue;
//  results show on res from the queue registers once they are written there.
//  Ready drops only while the queue holds more than two results (a byte can yield
//  two: payload/name plus the packet verdict). Synchronous reset clears all parser
//  state; max_payload returns to 997. No clearing pass after reset.

module transfer_packet_parser_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  tpp_item_if.sink      pkt,
  tpp_result_if.source  res
);
  import tpp_pkg::*;

  push_t push;   // results of the byte in the step stage
  logic  room;   // queue can take two more results

  // byte register, TLV walk, DATA checks, verdict
  tpp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pkt       (pkt),
    .room      (room),
    .push      (push)
  );

  // output decoupling; res.ready never reaches pkt.ready combinationally
  tpp_result_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

// ===== tb/transfer_packet_parser_checker.sv =====
// Checker for the transfer packet parser: predicts results per accepted byte and compares them.
`timescale 1ns / 1ps

module transfer_packet_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        pkt_valid,
  input  logic        pkt_ready,
  input  logic [7:0]  pkt_byte,
  input  logic        pkt_eop,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [1:0]  res_kind,
  input  logic [7:0]  res_byte,
  input  logic [2:0]  res_verdict,
  input  logic [63:0] res_file_size,
  input  logic [63:0] res_received_total,
  input  logic        res_last,
  output int          failures,
  output int          pending
);
  import tpp_pkg::*;

  // filename and payload results carry a zero verdict
  localparam logic [2:0] NO_VERDICT = 3'd0;

  // parser copy
  logic [15:0] payload_cap;
  phase_t      rx_phase;
  logic [15:0] byte_pos;
  logic [7:0]  ctl;
  field_step_t field_step;
  logic [7:0]  field_tag;
  logic [7:0]  field_left;
  int unsigned name_len;
  bit          bad;
  bit          have_size;
  logic [63:0] size_shift;
  logic [15:0] data_len;
  logic [63:0] size_expected;
  logic [63:0] bytes_kept;

  result_t step_results[$];
  result_t expected_results[$];
  result_t want;

  task automatic clear_packet();
    byte_pos   = '0;
    ctl        = '0;
    field_step = STEP_TYPE;
    field_tag  = '0;
    field_left = '0;
    name_len   = 0;
    bad        = 1'b0;
    have_size  = 1'b0;
    size_shift = '0;
    data_len   = '0;
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] v);
    result_t r;
    r.out_kind       = kind;
    r.out_byte       = b;
    r.verdict        = v;
    r.file_size      = size_expected;
    r.received_total = bytes_kept;
    r.out_last       = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    int unsigned idx;
    int unsigned cnt;
    logic [2:0]  v;
    idx = byte_pos;
    step_results.delete();
    if (idx >= MAX_PACKET) bad = 1'b1;
    if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;

    if (rx_phase == PH_WAIT) begin
      if (idx == 0) begin
        ctl = b;
        field_step = STEP_TYPE;
        if (b != CTL_START) bad = 1'b1;
      end else if (!bad) begin
        case (field_step)
          STEP_TYPE: begin
            field_tag  = b;
            field_step = STEP_LEN;
          end
          STEP_LEN: begin
            field_left = b;
            if (field_tag == TAG_SIZE) begin
              size_shift = '0;
              have_size  = 1'b1;
            end else if (field_tag == TAG_NAME) begin
              name_len = 0;
            end
            if (b != 8'h00) field_step = STEP_VALUE;
            else field_step = STEP_TYPE;
          end
          default: begin
            if (field_tag == TAG_SIZE) begin
              size_shift = {size_shift[55:0], b};
            end else if (field_tag == TAG_NAME && name_len < NAME_CAPACITY - 1) begin
              add_result(KIND_NAME, b, NO_VERDICT);
              name_len++;
            end
            field_left = field_left - 8'd1;
            if (field_left == 8'd0) field_step = STEP_TYPE;
          end
        endcase
      end
    end else begin
      if (idx == 0) begin
        ctl = b;
      end else if (ctl == CTL_DATA) begin
        if (idx == 1) begin
          data_len = {b, 8'h00};
        end else if (idx == 2) begin
          data_len[7:0] = b;
          if (data_len > payload_cap) bad = 1'b1;
        end else if (!bad && idx - 3 < data_len) begin
          add_result(KIND_PAYLOAD, b, NO_VERDICT);
        end
      end
    end

    if (eop) begin
      v = VERDICT_IGNORED;
      if (rx_phase == PH_WAIT) begin
        if (field_step == STEP_VALUE) bad = 1'b1;
        if (!bad && have_size) begin
          size_expected = size_shift;
          bytes_kept    = '0;
          rx_phase      = PH_RECV;
          v             = VERDICT_START_OK;
        end
      end else if (ctl == CTL_DATA) begin
        cnt = byte_pos;
        if (!bad && cnt >= 3 && cnt >= 3 + data_len) begin
          bytes_kept = bytes_kept + 64'(data_len);
          v = VERDICT_DATA_OK;
        end
      end else if (ctl == CTL_END && !bad) begin
        v = (bytes_kept == size_expected) ? VERDICT_END_MATCH : VERDICT_END_MISS;
        rx_phase = PH_WAIT;
      end
      add_result(KIND_VERDICT, 8'h00, v);
      clear_packet();
    end

    if (step_results.size() != 0) step_results[step_results.size() - 1].out_last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  task automatic report_field(input string field, input logic [63:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      payload_cap   = MAX_PAYLOAD_RESET;
      rx_phase      = PH_WAIT;
      size_expected = '0;
      bytes_kept    = '0;
      clear_packet();
      expected_results.delete();
      failures = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual kind %0d byte 0x%0h verdict %0d",
                   $time, res_kind, res_byte, res_verdict);
          failures++;
        end else begin
          want = expected_results.pop_front();
          report_field("out_kind", want.out_kind, res_kind);
          report_field("out_byte", want.out_byte, res_byte);
          report_field("verdict", want.verdict, res_verdict);
          report_field("file_size", want.file_size, res_file_size);
          report_field("received_total", want.received_total, res_received_total);
          report_field("out_last", want.out_last, res_last);
        end
      end
      if (cfg_we) payload_cap = cfg_wdata;
      if (pkt_valid && pkt_ready) parse_byte(pkt_byte, pkt_eop);
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/transfer_packet_parser_top_test.sv =====
// Testbench top for the transfer packet parser: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module transfer_packet_parser_top_test;
  import tpp_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int mismatch_count;
  int results_pending;

  tpp_item_if   pkt_if ();
  tpp_result_if res_if ();

  // quiet: no random gaps on that side
  bit          send_quiet;
  bit          take_quiet;
  logic [15:0] payload_limit;   // mirror of max_payload, used to shape DATA lengths
  int unsigned bytes_sent;
  logic [7:0]  frame[$];        // packet under construction

  transfer_packet_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pkt       (pkt_if),
    .res       (res_if)
  );

  transfer_packet_parser_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .pkt_valid          (pkt_if.valid),
    .pkt_ready          (pkt_if.ready),
    .pkt_byte           (pkt_if.rx_byte),
    .pkt_eop            (pkt_if.end_of_packet),
    .res_valid          (res_if.valid),
    .res_ready          (res_if.ready),
    .res_kind           (res_if.out_kind),
    .res_byte           (res_if.out_byte),
    .res_verdict        (res_if.verdict),
    .res_file_size      (res_if.file_size),
    .res_received_total (res_if.received_total),
    .res_last           (res_if.out_last),
    .failures           (mismatch_count),
    .pending            (results_pending)
  );

  // 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop. Slowest legal run (every gap and stall at its longest, two results
  // per byte) stays under 1 ms.
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic put_random(input int unsigned n);
    repeat (n) frame.push_back(rand_byte());
  endtask

  // Size field of nb value bytes, big-endian; bytes above the low 64 bits are junk
  // that the parser shifts out.
  task automatic put_size(input logic [63:0] v, input int unsigned nb);
    frame.push_back(TAG_SIZE);
    frame.push_back(8'(nb));
    for (int k = int'(nb) - 1; k >= 0; k--) begin
      frame.push_back(k >= 8 ? rand_byte() : v[8*k +: 8]);
    end
  endtask

  // Filler field: mostly short, a name now and then, rarely a long one.
  task automatic put_field();
    int unsigned len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
    frame.push_back(($urandom_range(0, 2) == 0) ? TAG_NAME : rand_byte());
    frame.push_back(8'(len));
    put_random(len);
  endtask

  // One byte transfer. Called at a falling edge, returns at a falling edge.
  // hold: keep valid low until every outstanding result has drained.
  task automatic send_byte(input logic [7:0] b, input logic eop, input bit hold);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    if (hold) begin
      pkt_if.valid <= 1'b0;
      do @(negedge clk); while (results_pending != 0);
    end
    if (gap != 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_if.valid         <= 1'b1;
    pkt_if.rx_byte       <= b;
    pkt_if.end_of_packet <= eop;
    do @(posedge clk); while (!pkt_if.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends the frame, end_of_packet on its last byte; drains the results before
  // byte hold_at, and now and then at random.
  task automatic send_frame(input int hold_at);
    for (int i = 0; i < frame.size(); i++) begin
      send_byte(frame[i], i == frame.size() - 1, i == hold_at || $urandom_range(0, 399) == 0);
    end
    frame.delete();
  endtask

  // Idle point: all results in, plus a few cycles for bytes that yield nothing.
  task automatic wait_idle();
    pkt_if.valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_max_payload(input logic [15:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we        <= 1'b0;
    payload_limit = v;
  endtask

  // One transfer session: START, a few DATA packets, END. Most sessions are clean
  // with random content; some get a broken START, a mangled DATA, a stray
  // control byte or no END at all.
  task automatic run_session();
    int unsigned n_data;
    int unsigned cap;
    int unsigned total;
    int unsigned nb;
    int unsigned flaw;
    int unsigned declared;
    int unsigned nbytes;
    int unsigned lens[4];
    logic [63:0] size_value;
    logic [63:0] rest;
    n_data = $urandom_range(0, 4);
    cap    = (payload_limit < 24) ? payload_limit : 24;
    total  = 0;
    for (int i = 0; i < n_data; i++) begin
      lens[i] = $urandom_range(0, cap);
      total += lens[i];
    end
    // usually the size matches what the DATA packets will carry
    size_value = ($urandom_range(0, 3) != 0) ? 64'(total) : {$urandom, $urandom};

    // START flaw: 0 no later size field, 1 field overrun, 2 random control, 3 lone type
    flaw  = $urandom_range(0, 9);
    frame = '{CTL_START};
    repeat ($urandom_range(0, 2)) put_field();
    if ($urandom_range(0, 7) == 0) put_size({$urandom, $urandom}, 8);  // overridden later unless flaw is 0
    if (flaw != 0) begin
      nb   = 0;
      rest = size_value;
      while (rest != 0) begin
        nb++;
        rest = rest >> 8;
      end
      if ($urandom_range(0, 9) == 0) nb = $urandom_range(9, 10);
      else nb = nb + $urandom_range(0, 8 - nb);
      put_size(size_value, nb);
    end
    if ($urandom_range(0, 1) != 0) put_field();
    if (flaw == 1) begin
      declared = $urandom_range(1, 8);
      frame.push_back(rand_byte());
      frame.push_back(8'(declared));
      put_random($urandom_range(0, declared - 1));
    end
    if (flaw == 2) frame[0] = rand_byte();
    if (flaw == 3) frame.push_back(rand_byte());
    send_frame(-1);

    for (int i = 0; i < n_data; i++) begin
      declared = lens[i];
      nbytes   = lens[i];
      // DATA flaw: 0 short payload, 1 trailing bytes, 2 random length,
      // 3 stray control, 4 truncated header
      flaw = $urandom_range(0, 11);
      case (flaw)
        0: declared = lens[i] + $urandom_range(1, 3);
        1: nbytes = lens[i] + $urandom_range(1, 3);
        2: begin
          declared = $urandom_range(0, 65535);
          nbytes   = (declared < 6) ? declared : 6;
        end
        default: ;
      endcase
      if (flaw == 3) begin
        frame = '{rand_byte()};
        put_random($urandom_range(0, 4));
      end else if (flaw == 4) begin
        frame = '{CTL_DATA};
        put_random($urandom_range(0, 1));
      end else begin
        frame = '{CTL_DATA, 8'(declared >> 8), 8'(declared)};
        put_random(nbytes);
      end
      send_frame(-1);
    end

    if ($urandom_range(0, 15) != 0) begin
      frame = '{CTL_END};
      put_random($urandom_range(0, 2));
      send_frame(-1);
    end
  endtask

  // Result side: ready drops for a random number of cycles before each transfer,
  // with quiet stretches that come and go.
  initial begin
    int unsigned gap;
    res_if.ready = 1'b0;
    take_quiet   = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_quiet = ~take_quiet;
      gap = draw_gap(take_quiet);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] limits[6];
    int unsigned phase_end;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    pkt_if.valid         = 1'b0;
    pkt_if.rx_byte       = '0;
    pkt_if.end_of_packet = 1'b0;
    send_quiet           = 1'b0;
    payload_limit        = MAX_PAYLOAD_RESET;
    bytes_sent           = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, max_payload at its reset value ----
    // DATA while waiting: ignored
    frame = '{CTL_DATA, 8'h00, 8'h01, 8'hAA};
    send_frame(-1);
    // START of one byte: no size field
    frame = '{CTL_START};
    send_frame(-1);
    // name only: bytes go out, then rejected for the missing size
    frame = '{CTL_START, TAG_NAME, 8'd3, 8'h61, 8'h62, 8'h63};
    send_frame(-1);
    // size field runs past the packet end
    frame = '{CTL_START, TAG_SIZE, 8'd5, 8'h01, 8'h02};
    send_frame(-1);
    // accepted, size 0x1234; a lone type byte at the end is fine
    frame = '{CTL_START, TAG_SIZE, 8'd2, 8'h12, 8'h34, TAG_NAME};
    send_frame(-1);
    // DATA with a truncated header
    frame = '{CTL_DATA, 8'h00};
    send_frame(-1);
    frame = '{CTL_DATA};
    send_frame(-1);
    // length 998, one above the limit
    frame = '{CTL_DATA, 8'h03, 8'hE6, 8'h55};
    send_frame(-1);
    // length 997, at the limit, but short
    frame = '{CTL_DATA, 8'h03, 8'hE5, 8'h55, 8'h66};
    send_frame(-1);
    // short payload
    frame = '{CTL_DATA, 8'h00, 8'h03, 8'hAA, 8'hBB};
    send_frame(-1);
    // trailing bytes ignored; sender drains everything mid-packet first
    frame = '{CTL_DATA, 8'h00, 8'h02, 8'hAA, 8'hBB, 8'hCC, 8'hDD};
    send_frame(3);
    // empty payload
    frame = '{CTL_DATA, 8'h00, 8'h00};
    send_frame(-1);
    // START and an unknown control while receiving
    frame = '{CTL_START, TAG_SIZE, 8'd1, 8'h00};
    send_frame(-1);
    frame = '{8'hFF, 8'h00};
    send_frame(-1);
    // END with 2 of 0x1234 bytes: mismatch
    frame = '{CTL_END};
    send_frame(-1);
    // 9-byte size, then an empty size field that wins, two names (one of them
    // full length) and an empty unknown field
    frame = '{CTL_START, TAG_SIZE, 8'd9, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
              8'h06, 8'h07, 8'h08, TAG_SIZE, 8'h00, TAG_NAME, 8'd2, 8'h78, 8'h79,
              TAG_NAME, 8'd255};
    put_random(255);
    frame.push_back(8'h7F);
    frame.push_back(8'h00);
    send_frame(-1);
    frame = '{CTL_END, 8'hFF};
    send_frame(-1);
    // 9-byte size whose top byte falls off: size 2
    frame = '{CTL_START, TAG_NAME, 8'd0, TAG_SIZE, 8'd9, 8'hFF, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h02};
    send_frame(-1);
    frame = '{CTL_DATA, 8'h00, 8'h02, 8'h11, 8'hEE};
    send_frame(-1);

    // limit 0: only empty DATA passes
    set_max_payload(16'd0);
    frame = '{CTL_START, TAG_SIZE, 8'd1, 8'h00};
    send_frame(-1);
    frame = '{CTL_DATA, 8'h00, 8'h00};
    send_frame(-1);
    frame = '{CTL_DATA, 8'h00, 8'h01, 8'hAA};
    send_frame(-1);

    // limit 65535: a packet one byte past the packet limit, sent back to back;
    // the last byte is dropped and the packet rejected
    set_max_payload(16'hFFFF);
    send_quiet = 1'b1;
    frame = '{CTL_DATA, 8'h03, 8'hFE};
    put_random(1022);
    send_frame(-1);
    send_quiet = 1'b0;
    frame = '{CTL_END};
    send_frame(-1);

    // ---- random part: one max_payload setting per stretch ----
    limits[0] = MAX_PAYLOAD_RESET;
    limits[1] = 16'd0;
    limits[2] = 16'hFFFF;
    limits[3] = 16'd5;
    limits[4] = 16'($urandom);
    limits[5] = 16'($urandom_range(20, 300));
    for (int p = 0; p < 6; p++) begin
      set_max_payload(limits[p]);
      send_quiet = ($urandom_range(0, 2) == 0);
      phase_end  = bytes_sent + 40;
      while (bytes_sent < phase_end) run_session();
    end

    wait_idle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tpp_pkg.sv
rtl/tpp_ifs.sv
rtl/tpp_parse_core.sv
rtl/tpp_result_fifo.sv
rtl/transfer_packet_parser_top.sv
tb/transfer_packet_parser_checker.sv
tb/transfer_packet_parser_top_test.sv
